### rtl/core/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, register indexes, float constants and leading-zero helpers
// for the pcm16 / float32 sample converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_TO_INTEGER    = 2'd0;
  localparam logic [1:0] REG_SAMPLE_SIGNED = 2'd1;
  localparam logic [1:0] REG_SCALE_MODE    = 2'd2;
  localparam logic [1:0] REG_CUSTOM_SCALE  = 2'd3;

  // scale mode codes
  localparam logic [1:0] SCALE_NONE   = 2'd0;
  localparam logic [1:0] SCALE_UNIT   = 2'd1;
  localparam logic [1:0] SCALE_CUSTOM = 2'd2;

  // float32 bit patterns
  localparam logic [31:0] F32_ONE        = 32'h3F80_0000;
  localparam logic [31:0] F32_32768      = 32'h4700_0000;
  localparam logic [31:0] F32_INV_32768  = 32'h3800_0000;
  localparam logic [31:0] F32_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] F32_QUIET_BIT  = 32'h0040_0000;

  localparam int unsigned NUM_STAGES = 6;

  typedef struct packed {
    logic to_int;
    logic sgn;
  } ctrl_t;

  typedef struct packed {
    logic       to_integer;
    logic       sample_signed;
    logic [1:0] scale_mode;
    logic [31:0] custom_scale;
  } cfg_t;

  function automatic logic [3:0] lzc16(input logic [15:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 4'(15 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pcf_regs.sv
// ----------------------------------------------------------------------------
// pcf_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output pcf_pkg::cfg_t    cfg_o
);

  pcf_pkg::cfg_t cfg_q;
  logic          wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.to_integer    <= 1'b0;
      cfg_q.sample_signed <= 1'b1;
      cfg_q.scale_mode    <= pcf_pkg::SCALE_NONE;
      cfg_q.custom_scale  <= pcf_pkg::F32_ONE;
    end else if (wr) begin
      case (paddr[3:2])
        pcf_pkg::REG_TO_INTEGER:    cfg_q.to_integer    <= pwdata[0];
        pcf_pkg::REG_SAMPLE_SIGNED: cfg_q.sample_signed <= pwdata[0];
        pcf_pkg::REG_SCALE_MODE:    cfg_q.scale_mode    <= pwdata[1:0];
        pcf_pkg::REG_CUSTOM_SCALE:  cfg_q.custom_scale  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pcf_pkg::REG_TO_INTEGER:    prdata = {31'd0, cfg_q.to_integer};
      pcf_pkg::REG_SAMPLE_SIGNED: prdata = {31'd0, cfg_q.sample_signed};
      pcf_pkg::REG_SCALE_MODE:    prdata = {30'd0, cfg_q.scale_mode};
      pcf_pkg::REG_CUSTOM_SCALE:  prdata = cfg_q.custom_scale;
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/pcf_front.sv
// ----------------------------------------------------------------------------
// pcf_front
// Operand stage: integer to float conversion and scale selection.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_front (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [31:0]   sample_in_i,
  input  pcf_pkg::cfg_t      cfg_i,
  output logic [31:0]        a_o,
  output logic [31:0]        b_o,
  output pcf_pkg::ctrl_t     ctrl_o
);

  logic [15:0]    raw;
  logic           neg;
  logic [15:0]    mag;
  logic [3:0]     lz;
  logic [15:0]    norm;
  logic [31:0]    int_f;
  logic [31:0]    a_d, b_d, a_q, b_q;
  pcf_pkg::ctrl_t ctrl_d, ctrl_q;

  always_comb begin
    raw  = sample_in_i[15:0];
    neg  = cfg_i.sample_signed & raw[15];
    mag  = neg ? (16'd0 - raw) : raw;
    lz   = pcf_pkg::lzc16(mag);
    norm = mag << lz;
    if (mag == 16'd0) begin
      int_f = 32'd0;
    end else begin
      int_f = {neg, 8'(8'd142 - {4'd0, lz}), norm[14:0], 8'd0};
    end
    a_d = cfg_i.to_integer ? sample_in_i : int_f;
    case (cfg_i.scale_mode)
      pcf_pkg::SCALE_UNIT:
        b_d = cfg_i.to_integer ? pcf_pkg::F32_32768 : pcf_pkg::F32_INV_32768;
      pcf_pkg::SCALE_CUSTOM: b_d = cfg_i.custom_scale;
      default:               b_d = pcf_pkg::F32_ONE;
    endcase
    ctrl_d.to_int = cfg_i.to_integer;
    ctrl_d.sgn    = cfg_i.sample_signed;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign a_o    = a_q;
  assign b_o    = b_q;
  assign ctrl_o = ctrl_q;

endmodule

`default_nettype wire

### rtl/core/pcf_fmul.sv
// ----------------------------------------------------------------------------
// pcf_fmul
// Four-stage float32 multiplier, round to nearest even, with subnormals:
// mantissa product, leading-zero count, normalize shift, round and pack.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_fmul (
  input  wire logic          clk_i,
  input  wire logic [3:0]    en_i,
  input  wire logic [31:0]   a_i,
  input  wire logic [31:0]   b_i,
  input  pcf_pkg::ctrl_t     ctrl_i,
  output logic [31:0]        res_o,
  output pcf_pkg::ctrl_t     ctrl_o
);

  // ---- product stage
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        spec_d;
  logic [31:0] spec_val_d;
  logic [9:0]  esum_d;

  logic [47:0]    p1_q;
  logic [9:0]     esum1_q;
  logic           sign1_q, spec1_q;
  logic [31:0]    spv1_q;
  pcf_pkg::ctrl_t ctrl1_q;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    fa     = a_i[22:0];
    fb     = b_i[22:0];
    a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    esum_d = 10'((ea == 8'd0) ? 8'd1 : ea) + 10'((eb == 8'd0) ? 8'd1 : eb);
    spec_d = 1'b1;
    if (a_nan) begin
      spec_val_d = a_i | pcf_pkg::F32_QUIET_BIT;
    end else if (b_nan) begin
      spec_val_d = b_i | pcf_pkg::F32_QUIET_BIT;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      spec_val_d = pcf_pkg::F32_DEFAULT_NAN;
    end else if (a_inf || b_inf) begin
      spec_val_d = {a_i[31] ^ b_i[31], 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      spec_val_d = {a_i[31] ^ b_i[31], 31'd0};
    end else begin
      spec_d     = 1'b0;
      spec_val_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q    <= {24'd0, (ea != 8'd0), fa} * {24'd0, (eb != 8'd0), fb};
      esum1_q <= esum_d;
      sign1_q <= a_i[31] ^ b_i[31];
      spec1_q <= spec_d;
      spv1_q  <= spec_val_d;
      ctrl1_q <= ctrl_i;
    end
  end

  // ---- leading-zero stage
  logic [47:0]        p2_q;
  logic [5:0]         lz2_q;
  logic signed [10:0] e2_q;
  logic               sign2_q, spec2_q;
  logic [31:0]        spv2_q;
  pcf_pkg::ctrl_t     ctrl2_q;
  logic [5:0]         lz2_d;

  assign lz2_d = pcf_pkg::lzc48(p1_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p2_q    <= p1_q;
      lz2_q   <= lz2_d;
      // biased result exponent before rounding
      e2_q    <= 11'(esum1_q) - 11'(lz2_d) - 11'd126;
      sign2_q <= sign1_q;
      spec2_q <= spec1_q;
      spv2_q  <= spv1_q;
      ctrl2_q <= ctrl1_q;
    end
  end

  // ---- normalize stage
  logic [47:0]        nrm, shr, lostmask;
  logic               ge1;
  logic [10:0]        dd;
  logic [4:0]         d;

  logic [23:0]        kept3_q;
  logic               g3_q, st3_q, ovf3_q;
  logic [7:0]         base3_q;
  logic               sign3_q, spec3_q;
  logic [31:0]        spv3_q;
  pcf_pkg::ctrl_t     ctrl3_q;

  always_comb begin
    nrm = p2_q << lz2_q;
    ge1 = e2_q > 11'sd0;
    dd  = 11'(11'sd1 - e2_q);
    if (ge1) begin
      d = 5'd0;
    end else if (dd > 11'd26) begin
      d = 5'd26;
    end else begin
      d = dd[4:0];
    end
    shr      = nrm >> d;
    lostmask = (48'd1 << d) - 48'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      kept3_q <= shr[47:24];
      g3_q    <= shr[23];
      st3_q   <= (|shr[22:0]) | (|(nrm & lostmask));
      ovf3_q  <= e2_q >= 11'sd255;
      base3_q <= ge1 ? 8'(e2_q - 11'sd1) : 8'd0;
      sign3_q <= sign2_q;
      spec3_q <= spec2_q;
      spv3_q  <= spv2_q;
      ctrl3_q <= ctrl2_q;
    end
  end

  // ---- round and pack stage
  logic        inc;
  logic [24:0] m;
  logic [30:0] sum;
  logic [31:0] res_d, res4_q;
  pcf_pkg::ctrl_t ctrl4_q;

  always_comb begin
    inc = g3_q & (st3_q | kept3_q[0]);
    m   = 25'(kept3_q) + 25'(inc);
    // hidden bit carries into the exponent field
    sum = {base3_q, 23'd0} + {6'd0, m};
    if (spec3_q) begin
      res_d = spv3_q;
    end else if (ovf3_q || (sum[30:23] == 8'hFF)) begin
      res_d = {sign3_q, 8'hFF, 23'd0};
    end else begin
      res_d = {sign3_q, sum};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res4_q  <= res_d;
      ctrl4_q <= ctrl3_q;
    end
  end

  assign res_o  = res4_q;
  assign ctrl_o = ctrl4_q;

endmodule

`default_nettype wire

### rtl/core/pcf_back.sv
// ----------------------------------------------------------------------------
// pcf_back
// Output stage: float to 16-bit integer with saturation, or float pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_back (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [31:0]   res_i,
  input  pcf_pkg::ctrl_t     ctrl_i,
  output logic [31:0]        sample_out_o,
  output pcf_pkg::ctrl_t     ctrl_o
);

  logic           s;
  logic [7:0]     ex;
  logic [23:0]    mant;
  logic           nan, big, tiny;
  logic [7:0]     shamt8;
  logic [4:0]     shamt;
  logic [23:0]    shifted;
  logic [15:0]    mag;
  logic           fracnz;
  logic [15:0]    ival;
  logic [31:0]    out_d, out_q;
  pcf_pkg::ctrl_t ctrl_q;

  always_comb begin
    s       = res_i[31];
    ex      = res_i[30:23];
    mant    = {1'b1, res_i[22:0]};
    nan     = (ex == 8'hFF) && (res_i[22:0] != 23'd0);
    big     = ex >= 8'd143;
    tiny    = ex < 8'd127;
    shamt8  = 8'd150 - ex;
    shamt   = shamt8[4:0];
    shifted = mant >> shamt;
    if (tiny || big) begin
      mag    = 16'd0;
      fracnz = (ex != 8'd0) || (res_i[22:0] != 23'd0);
    end else begin
      mag    = shifted[15:0];
      fracnz = |(mant & ((24'd1 << shamt) - 24'd1));
    end
    if (nan) begin
      ival = 16'd0;
    end else if (ctrl_i.sgn) begin
      if (!s) begin
        ival = (big || mag >= 16'h7FFF) ? 16'h7FFF : mag;
      end else if (big || mag > 16'h8000 || (mag == 16'h8000 && fracnz)) begin
        ival = 16'h8000;
      end else begin
        ival = 16'd0 - mag;
      end
    end else begin
      if (s) begin
        ival = 16'd0;
      end else begin
        ival = (big || mag == 16'hFFFF) ? 16'hFFFF : mag;
      end
    end
    out_d = ctrl_i.to_int ? {16'd0, ival} : res_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q  <= out_d;
      ctrl_q <= ctrl_i;
    end
  end

  assign sample_out_o = out_q;
  assign ctrl_o       = ctrl_q;

endmodule

`default_nettype wire

### rtl/core/pcm16_float32_converter_unit.sv
// ----------------------------------------------------------------------------
// pcm16_float32_converter_unit
// Path: six pipeline registers from input word accept to output word valid.
// Throughput: one word per cycle while out_ready_i is high; a full stage holds
// under stall while empty stages before it still fill.
// Reset: asynchronous active low, clears valid bits and returns configuration
// to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm16_float32_converter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] sample_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      sample_out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned NS = pcf_pkg::NUM_STAGES;

  pcf_pkg::cfg_t  cfg;
  logic [NS-1:0]  vld_q;
  logic [NS:0]    en;
  logic [31:0]    a, b, res;
  pcf_pkg::ctrl_t ctrl_f, ctrl_m, ctrl_b;

  // a stage loads when it is empty or its successor moves
  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];

  pcf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcf_front u_front (
    .clk_i       (clk_i),
    .en_i        (en[0]),
    .sample_in_i (sample_in_i),
    .cfg_i       (cfg),
    .a_o         (a),
    .b_o         (b),
    .ctrl_o      (ctrl_f)
  );

  pcf_fmul u_fmul (
    .clk_i  (clk_i),
    .en_i   (en[4:1]),
    .a_i    (a),
    .b_i    (b),
    .ctrl_i (ctrl_f),
    .res_o  (res),
    .ctrl_o (ctrl_m)
  );

  pcf_back u_back (
    .clk_i        (clk_i),
    .en_i         (en[5]),
    .res_i        (res),
    .ctrl_i       (ctrl_m),
    .sample_out_o (sample_out_o),
    .ctrl_o       (ctrl_b)
  );

  // sink ready means the pipe never backs up to the source
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o) else $error("input stalled with sink ready");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0]) else $error("accepted word lost");

  a_int_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ctrl_b.to_int |-> sample_out_o[31:16] == 16'd0)
    else $error("integer word has upper bits set");

endmodule

`default_nettype wire

### tb/sv/pcf_result_checker.sv
// ----------------------------------------------------------------------------
// pcf_result_checker
// Watches the sample and register ports of the pcm16 / float32 converter,
// predicts each output word from the accepted input word and the register
// values written so far, and compares in arrival order.
// ----------------------------------------------------------------------------
module pcf_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] sample_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] sample_out_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  pcf_pkg::cfg_t cfg;
  logic [31:0]   expected_samples[$];
  int            fails;
  int            checked;

  assign fail_count_o = fails;
  assign pending_o    = expected_samples.size();
  assign checked_o    = checked;

  // float32 pattern to an exact double
  function automatic real widen_f32(input logic [31:0] b);
    logic [63:0] d;
    logic [23:0] m;
    int          e;
    e = int'(b[30:23]);
    if (e == 255) begin
      d = {b[31], 11'h7FF, b[22:0], 29'b0};
    end else if (e == 0) begin
      if (b[22:0] == 23'b0) begin
        d = {b[31], 63'b0};
      end else begin
        m = {1'b0, b[22:0]};
        e = 1;
        while (!m[23]) begin
          m = m << 1;
          e--;
        end
        d = {b[31], 11'(e + 896), m[22:0], 29'b0};
      end
    end else begin
      d = {b[31], 11'(e + 896), b[22:0], 29'b0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic bit is_nan_real(input real r);
    logic [63:0] d;
    d = $realtobits(r);
    return (d[62:52] == 11'h7FF) && (d[51:0] != 52'b0);
  endfunction

  // round a (non-NaN) double to float32, nearest even, with subnormals
  function automatic logic [31:0] round_to_f32(input real r);
    logic [63:0] d;
    logic [63:0] mant;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic        s;
    int          ex;
    int          sh;
    d  = $realtobits(r);
    s  = d[63];
    if (d[62:52] == 11'h7FF) return {s, 8'hFF, 23'b0};
    if (d[62:52] == 11'h000) return {s, 31'b0};
    ex   = int'(d[62:52]) - 896;
    mant = {11'b0, 1'b1, d[51:0]};
    sh   = (ex >= 1) ? 29 : 30 - ex;
    if (sh >= 55) return {s, 31'b0};
    kept = mant >> sh;
    rem  = mant & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (ex >= 1) begin
      if (kept[24]) begin
        kept = kept >> 1;
        ex++;
      end
      if (ex >= 255) return {s, 8'hFF, 23'b0};
      return {s, 8'(ex), kept[22:0]};
    end
    // a carry into bit 23 gives the smallest normal by itself
    return {s, kept[30:0]};
  endfunction

  function automatic logic [31:0] convert_sample(input pcf_pkg::cfg_t c,
                                                 input logic [31:0] raw);
    real         a;
    real         k;
    real         p;
    real         v;
    logic [31:0] f;
    if (c.to_integer) begin
      a = widen_f32(raw);
      if (c.scale_mode == pcf_pkg::SCALE_UNIT) k = widen_f32(pcf_pkg::F32_32768);
      else if (c.scale_mode == pcf_pkg::SCALE_CUSTOM) k = widen_f32(c.custom_scale);
      else k = 1.0;
      p = a * k;
      if (is_nan_real(a) || is_nan_real(k) || is_nan_real(p)) return 32'h0;
      f = round_to_f32(p);
      v = widen_f32(f);
      if (c.sample_signed) begin
        if (v >= 32767.0) return 32'h0000_7FFF;
        if (v < -32768.0) return 32'h0000_8000;
      end else begin
        if (v >= 65535.0) return 32'h0000_FFFF;
        if (v < 0.0) return 32'h0;
      end
      return {16'b0, 16'($rtoi(v))};
    end
    if (c.sample_signed) a = real'($signed(raw[15:0]));
    else a = real'(raw[15:0]);
    if (c.scale_mode == pcf_pkg::SCALE_UNIT) k = widen_f32(pcf_pkg::F32_INV_32768);
    else if (c.scale_mode == pcf_pkg::SCALE_CUSTOM) k = widen_f32(c.custom_scale);
    else k = 1.0;
    if (is_nan_real(k)) return c.custom_scale | pcf_pkg::F32_QUIET_BIT;
    p = a * k;
    // zero times infinity
    if (is_nan_real(p)) return pcf_pkg::F32_DEFAULT_NAN;
    return round_to_f32(p);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      cfg.to_integer    <= 1'b0;
      cfg.sample_signed <= 1'b1;
      cfg.scale_mode    <= pcf_pkg::SCALE_NONE;
      cfg.custom_scale  <= pcf_pkg::F32_ONE;
      expected_samples.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          pcf_pkg::REG_TO_INTEGER:    cfg.to_integer    <= pwdata_i[0];
          pcf_pkg::REG_SAMPLE_SIGNED: cfg.sample_signed <= pwdata_i[0];
          pcf_pkg::REG_SCALE_MODE:    cfg.scale_mode    <= pwdata_i[1:0];
          pcf_pkg::REG_CUSTOM_SCALE:  cfg.custom_scale  <= pwdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected word: sample_out actual %h", sample_out_i);
          fails++;
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (sample_out_i !== want) begin
            $error("mismatch on sample_out: expected %h actual %h", want, sample_out_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_samples.push_back(convert_sample(cfg, sample_in_i));
    end
  end

endmodule

### tb/sv/tb_pcm16_float32_converter_unit.sv
// ----------------------------------------------------------------------------
// tb_pcm16_float32_converter_unit
// Drives directed and random samples through the converter in each direction,
// sample type and scale mode, with bursty input, a stalling output and one
// long output hold; a checker module predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_pcm16_float32_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] sample_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] sample_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          checked;
  int          ready_pct = 100;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;
  int          sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pcm16_float32_converter_unit DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .sample_in_i(sample_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .sample_out_o(sample_out),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pcf_result_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .sample_in_i(sample_in),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .sample_out_i(sample_out),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // output side: random stall pattern plus one long hold on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_word(input logic [31:0] w);
    in_valid  <= 1'b1;
    sample_in <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_mode(input bit to_int, input bit sgn, input logic [1:0] mode,
                          input logic [31:0] scale);
    drain();
    reg_write(pcf_pkg::REG_TO_INTEGER, {31'b0, to_int});
    reg_write(pcf_pkg::REG_SAMPLE_SIGNED, {31'b0, sgn});
    reg_write(pcf_pkg::REG_SCALE_MODE, {30'b0, mode});
    reg_write(pcf_pkg::REG_CUSTOM_SCALE, scale);
  endtask

  function automatic logic [31:0] pick_scale_bits();
    logic [31:0] picks[10];
    picks = '{32'h3F80_0000, 32'h3F00_0000, 32'h4700_0000, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0001, 32'h0000_0001, 32'h0000_0000, 32'hC040_0000, 32'h7F7F_FFFF};
    if ($urandom_range(0, 1)) return picks[$urandom_range(0, 9)];
    return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] pick_float_bits();
    case ($urandom_range(0, 3))
      0: return $urandom;
      // near the saturation points
      1: return {1'($urandom), 8'($urandom_range(140, 143)), 23'($urandom)};
      2: return {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FC0_0000 | $urandom_range(0, 255);
          1: return {1'($urandom), 31'h7F80_0000};
          2: return {1'($urandom), 31'h0};
          3: return {1'($urandom), 9'b0, 22'($urandom)};
          4: return 32'h46FF_FE00 + $urandom_range(0, 511) - 256;
          default: return 32'h477F_FF00 + $urandom_range(0, 511) - 256;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [31:0] int_dir[6];
    logic [31:0] flt_dir[14];
    logic [31:0] scale;
    int          n;
    int_dir = '{32'h0000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_FFFF,
                32'hFFFF_0001, 32'hABCD_8001};
    flt_dir = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                32'h46FF_FE00, 32'h46FF_FF00, 32'h4700_0000, 32'hC700_0000, 32'hC700_0100,
                32'h477F_FF00, 32'h4780_0000, 32'hBF00_0000, 32'h0000_0001};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: integer words, then float words signed and unsigned
    foreach (int_dir[i]) push_word(int_dir[i]);
    set_mode(1'b1, 1'b1, pcf_pkg::SCALE_NONE, pcf_pkg::F32_ONE);
    foreach (flt_dir[i]) push_word(flt_dir[i]);
    set_mode(1'b1, 1'b0, pcf_pkg::SCALE_NONE, pcf_pkg::F32_ONE);
    for (int i = 8; i < 14; i++) push_word(flt_dir[i]);

    for (int ph = 0; ph < 16; ph++) begin
      scale = (ph == 0) ? 32'h7FC0_0001 : pick_scale_bits();
      set_mode(ph[0], ph[1], ph[3:2], scale);
      ready_pct = (ph % 3 == 0) ? 100 : ((ph % 3 == 1) ? 70 : 25);
      // fill the pipeline against a long output hold
      if (ph == 5) hold_req = 1'b1;
      n = 0;
      while (n < 68) begin
        for (int b = $urandom_range(1, 40); b > 0 && n < 68; b--) begin
          push_word(ph[0] ? pick_float_bits() : $urandom);
          n++;
        end
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end

    drain();
    $display("sent %0d sample words, checked %0d results", sent, checked);
    $display("covered both directions, both sample types and all four scale modes");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/pcf_pkg.sv
rtl/core/pcf_regs.sv
rtl/core/pcf_front.sv
rtl/core/pcf_fmul.sv
rtl/core/pcf_back.sv
rtl/core/pcm16_float32_converter_unit.sv
tb/sv/pcf_result_checker.sv
tb/sv/tb_pcm16_float32_converter_unit.sv
